// ===== design/mmsq_pkg.sv =====
`default_nettype none
package mmsq_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned DITHER_W  = 16;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned BITS_W    = 4;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BYTES_W   = 4;
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_QUANT_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LENGTH = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [DITHER_W-1:0]        random_fraction;
    logic                       last_in_bucket;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         level_code;
    logic signed [SAMPLE_W-1:0] error_feedback;
    logic signed [SAMPLE_W-1:0] bucket_max;
    logic signed [SAMPLE_W-1:0] bucket_min;
    logic                       packed_valid;
    logic [WORD_W-1:0]          packed_word;
    logic [BYTES_W-1:0]         packed_bytes;
    logic                       last_result;
  } out_t;

endpackage
`default_nettype wire

// ===== design/mmsq_if.sv =====
`default_nettype none
interface mmsq_in_if import mmsq_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmsq_out_if import mmsq_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mmsq_ram.sv =====
`default_nettype none
module mmsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/maxmin_stochastic_quantizer_top.sv =====
// Channel  Dir  Payload                                   Transfer
// in_if    in   sample_value, random_fraction, last flag  valid & ready
// out_if   out  level, error feedback, max/min, packing   valid & ready
//
// Samples are accepted while the bucket loads. When a bucket closes, each
// element runs through RAM read, offset, products, sum, an 8-step level
// division, a rounding product and a 41-step division by 2^bits-1 for the
// error; when max equals min, the sum, both divisions and the rounding product
// are skipped. Input is not accepted while a bucket is being emitted. An output
// stall holds the result register and the element sequencer.
// Reset clears the control state; the sample memories need no clearing.
`default_nettype none
module maxmin_stochastic_quantizer_top import mmsq_pkg::*; #(
  parameter int unsigned MAX_BUCKET = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  mmsq_in_if.sink                   in_if,
  mmsq_out_if.source                out_if
);
  localparam int unsigned IDX_W  = $clog2(MAX_BUCKET);
  localparam int unsigned FILL_W = $clog2(MAX_BUCKET + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_OFF  = 4'd2;
  localparam logic [3:0] S_PROD = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [BITS_W-1:0] qbits_q;
  logic [LEN_W-1:0]  blen_q;
  logic [FILL_W-1:0] fill_q, count_q, emit_q;
  logic signed [SAMPLE_W-1:0] max_q, min_q;

  // Effective configuration.
  logic [BITS_W-1:0] bits_eff;
  logic [LEVEL_W-1:0] dmax;
  logic [FILL_W-1:0] len_eff;
  logic [LEN_W-1:0]  len_c;

  always_comb begin
    bits_eff = qbits_q;
    if (qbits_q == '0) bits_eff = BITS_W'(1);
    if (qbits_q > BITS_W'(LEVEL_W)) bits_eff = BITS_W'(LEVEL_W);
    dmax = LEVEL_W'((9'd1 << bits_eff) - 9'd1);
    len_c = blen_q;
    if (blen_q == '0) len_c = LEN_W'(1);
    if (32'(blen_q) > MAX_BUCKET) len_c = LEN_W'(MAX_BUCKET);
    len_eff = FILL_W'(len_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qbits_q <= BITS_W'(4);
      blen_q  <= LEN_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_QUANT_BITS) qbits_q <= cfg_data_i[BITS_W-1:0];
      else if (cfg_index_i == REG_BUCKET_LENGTH) blen_q <= cfg_data_i[LEN_W-1:0];
    end
  end

  // Sample and dither memories.
  logic                in_xfer;
  logic [SAMPLE_W-1:0] s_rdata;
  logic [DITHER_W-1:0] r_rdata;
  logic [FILL_W-1:0]   fill_inc;
  logic                close;

  assign in_if.ready = (state_q == S_LOAD);
  assign in_xfer  = in_if.valid && in_if.ready;
  assign fill_inc = fill_q + FILL_W'(1);
  assign close    = (fill_inc >= len_eff) || in_if.data.last_in_bucket;

  mmsq_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_BUCKET)) u_sample_ram (
    .clk_i, .we_i(in_xfer), .waddr_i(fill_q[IDX_W-1:0]),
    .wdata_i(in_if.data.sample_value), .raddr_i(emit_q[IDX_W-1:0]),
    .rdata_o(s_rdata)
  );

  mmsq_ram #(.WIDTH(DITHER_W), .DEPTH(MAX_BUCKET)) u_dither_ram (
    .clk_i, .we_i(in_xfer), .waddr_i(fill_q[IDX_W-1:0]),
    .wdata_i(in_if.data.random_fraction), .raddr_i(emit_q[IDX_W-1:0]),
    .rdata_o(r_rdata)
  );

  // Datapath registers.
  logic [SAMPLE_W-1:0] off_q, range_q;
  logic [DITHER_W-1:0] dith_q;
  logic [39:0]         p1_q;
  logic [47:0]         p2_q;
  logic [56:0]         rem_q;
  logic [54:0]         dvs_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [40:0]         n2_q;
  logic [8:0]          rem2_q;
  logic [33:0]         quo_q;
  logic [5:0]          cnt_q;
  logic [WORD_W-1:0]   group_q;
  logic [2:0]          gcount_q;
  logic                out_valid_q;
  out_t                out_q;

  logic [8:0]  r2_try;
  logic [34:0] err_w;
  logic signed [SAMPLE_W-1:0] err_sat;
  logic [WORD_W-1:0] group_w;
  logic [3:0]  gcount_w;
  logic        last_el;

  always_comb begin
    r2_try   = {rem2_q[7:0], n2_q[40]};
    err_w    = {3'b0, off_q} - {1'b0, quo_q};
    if ($signed(err_w) > $signed(35'sh07FFFFFFF)) err_sat = 32'sh7FFFFFFF;
    else if ($signed(err_w) < -$signed(35'sh080000000)) err_sat = 32'sh80000000;
    else err_sat = err_w[SAMPLE_W-1:0];
    group_w  = group_q | (WORD_W'(level_q) << (6'(gcount_q) * 6'(bits_eff)));
    gcount_w = 4'(gcount_q) + 4'd1;
    last_el  = (emit_q + FILL_W'(1)) == count_q;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (in_xfer && close) state_d = S_RD;
      S_RD:   state_d = S_OFF;
      S_OFF:  state_d = S_PROD;
      S_PROD: state_d = (range_q == '0) ? S_ERR : S_SUM;
      S_SUM:  state_d = S_DIV1;
      S_DIV1: if (cnt_q == '0) state_d = S_MUL2;
      S_MUL2: state_d = S_DIV2;
      S_DIV2: if (cnt_q == '0) state_d = S_ERR;
      S_ERR:  state_d = S_OUT;
      S_OUT:  if (out_if.ready) state_d = last_el ? S_LOAD : S_RD;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      count_q     <= '0;
      emit_q      <= '0;
      max_q       <= '0;
      min_q       <= '0;
      cnt_q       <= '0;
      gcount_q    <= '0;
      group_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (fill_q == '0 || in_if.data.sample_value > max_q)
              max_q <= in_if.data.sample_value;
            if (fill_q == '0 || in_if.data.sample_value < min_q)
              min_q <= in_if.data.sample_value;
            if (close) begin
              fill_q   <= '0;
              count_q  <= fill_inc;
              emit_q   <= '0;
              gcount_q <= '0;
              group_q  <= '0;
            end else begin
              fill_q <= fill_inc;
            end
          end
        end
        S_SUM:  cnt_q <= 6'd7;
        S_DIV1: cnt_q <= cnt_q - 6'd1;
        S_MUL2: cnt_q <= 6'd40;
        S_DIV2: cnt_q <= cnt_q - 6'd1;
        S_ERR: begin
          out_valid_q <= 1'b1;
          if (gcount_w == 4'(GROUP_SIZE) || last_el) begin
            group_q  <= '0;
            gcount_q <= '0;
          end else begin
            group_q  <= group_w;
            gcount_q <= gcount_w[2:0];
          end
        end
        S_OUT: begin
          if (out_if.ready) begin
            out_valid_q <= 1'b0;
            emit_q      <= emit_q + FILL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_OFF: begin
        off_q   <= s_rdata - min_q;
        dith_q  <= r_rdata;
        range_q <= max_q - min_q;
      end
      S_PROD: begin
        p1_q    <= 40'(off_q) * 40'(dmax);
        p2_q    <= 48'(dith_q) * 48'(range_q);
        level_q <= '0;
        quo_q   <= '0;
      end
      S_SUM: begin
        rem_q <= {1'b0, p1_q, 16'b0} + 57'(p2_q);
        dvs_q <= {range_q, 23'b0};
      end
      S_DIV1: begin
        // One level bit per step, most significant first.
        if (rem_q >= 57'(dvs_q)) begin
          rem_q   <= rem_q - 57'(dvs_q);
          level_q <= {level_q[LEVEL_W-2:0], 1'b1};
        end else begin
          level_q <= {level_q[LEVEL_W-2:0], 1'b0};
        end
        dvs_q <= dvs_q >> 1;
      end
      S_MUL2: begin
        if (level_q > dmax) level_q <= dmax;
        n2_q   <= 41'((level_q > dmax ? dmax : level_q)) * 41'(range_q)
                  + 41'(dmax >> 1);
        rem2_q <= '0;
      end
      S_DIV2: begin
        n2_q <= {n2_q[39:0], 1'b0};
        if (r2_try >= 9'(dmax)) begin
          rem2_q <= r2_try - 9'(dmax);
          quo_q  <= {quo_q[32:0], 1'b1};
        end else begin
          rem2_q <= r2_try;
          quo_q  <= {quo_q[32:0], 1'b0};
        end
      end
      S_ERR: begin
        out_q.level_code     <= level_q;
        out_q.error_feedback <= err_sat;
        out_q.bucket_max     <= max_q;
        out_q.bucket_min     <= min_q;
        out_q.last_result    <= last_el;
        if (gcount_w == 4'(GROUP_SIZE) || last_el) begin
          out_q.packed_valid <= 1'b1;
          out_q.packed_word  <= group_w;
          out_q.packed_bytes <= BYTES_W'((8'(gcount_w) * 8'(bits_eff) + 8'd7) >> 3);
        end else begin
          out_q.packed_valid <= 1'b0;
          out_q.packed_word  <= '0;
          out_q.packed_bytes <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("input taken while result pending");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) < MAX_BUCKET) else $error("fill count out of range");
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.level_code <= dmax) else $error("level above max");
  a_last_packs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.last_result |-> out_if.data.packed_valid)
    else $error("last result without packed word");
`endif

endmodule
`default_nettype wire
